### rtl/wrlm_pkg.sv
// ----------------------------------------------------------------------------
// wrlm_pkg
// shared types and constants of the wildcard rule list matcher
// ----------------------------------------------------------------------------
`default_nettype none

package wrlm_pkg;

  localparam int NUM_RULES_DEF  = 4;
  localparam int RULE_BYTES_DEF = 8;
  localparam int RULE_SLOTS     = 4;
  localparam int ADDR_W         = 6;
  localparam int DATA_W         = 64;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [2:0] NO_MATCH  = 3'd4;

  // register index, taken from paddr bits above the 8-byte offset
  localparam logic [2:0] REG_RULE_BYTES_0 = 3'd0;
  localparam logic [2:0] REG_RULE_BYTES_1 = 3'd1;
  localparam logic [2:0] REG_RULE_BYTES_2 = 3'd2;
  localparam logic [2:0] REG_RULE_BYTES_3 = 3'd3;
  localparam logic [2:0] REG_RULE_LENGTHS = 3'd4;
  localparam logic [2:0] REG_NEGATE_MASK  = 3'd5;

  typedef struct packed {
    logic [7:0] name_byte;
    logic       byte_present;
    logic       is_last;
  } name_word_t;

  typedef struct packed {
    logic       accepted;
    logic [2:0] deciding_rule;
  } verdict_word_t;

  // what one cell hands to the next
  typedef struct packed {
    logic       valid;
    name_word_t word;
    logic       decided;
    logic       accepted;
    logic [2:0] rule;
  } stage_t;

endpackage

`default_nettype wire

### rtl/wrlm_regs.sv
// ----------------------------------------------------------------------------
// wrlm_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
`default_nettype none

module wrlm_regs (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        psel,
  input  wire logic                                        penable,
  input  wire logic                                        pwrite,
  input  wire logic [wrlm_pkg::ADDR_W-1:0]                 paddr,
  input  wire logic [wrlm_pkg::DATA_W-1:0]                 pwdata,
  output logic      [wrlm_pkg::DATA_W-1:0]                 prdata,
  output logic                                             pready,
  output logic      [wrlm_pkg::RULE_SLOTS-1:0][63:0]       rule_bytes,
  output logic      [15:0]                                 rule_lengths,
  output logic      [3:0]                                  rule_negate_mask
);
  import wrlm_pkg::*;

  logic [2:0] index;
  logic       wr_en;

  assign index  = paddr[ADDR_W-1:3];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rule_bytes       <= '0;
      rule_lengths     <= '0;
      rule_negate_mask <= '0;
    end else if (wr_en) begin
      case (index)
        REG_RULE_BYTES_0: rule_bytes[0]    <= pwdata;
        REG_RULE_BYTES_1: rule_bytes[1]    <= pwdata;
        REG_RULE_BYTES_2: rule_bytes[2]    <= pwdata;
        REG_RULE_BYTES_3: rule_bytes[3]    <= pwdata;
        REG_RULE_LENGTHS: rule_lengths     <= pwdata[15:0];
        REG_NEGATE_MASK:  rule_negate_mask <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (index)
      REG_RULE_BYTES_0: prdata = rule_bytes[0];
      REG_RULE_BYTES_1: prdata = rule_bytes[1];
      REG_RULE_BYTES_2: prdata = rule_bytes[2];
      REG_RULE_BYTES_3: prdata = rule_bytes[3];
      REG_RULE_LENGTHS: prdata = {48'd0, rule_lengths};
      REG_NEGATE_MASK:  prdata = {60'd0, rule_negate_mask};
      default:          prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

### rtl/wrlm_cell.sv
// ----------------------------------------------------------------------------
// wrlm_cell
// one rule: holds its match column and passes the word on to the next cell
// ----------------------------------------------------------------------------
`default_nettype none

module wrlm_cell #(
  parameter int         RULE_BYTES = wrlm_pkg::RULE_BYTES_DEF,
  parameter logic [2:0] RULE_IDX   = 3'd0
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire wrlm_pkg::stage_t          stage_in,
  output wrlm_pkg::stage_t               stage_out,
  input  wire logic [8*RULE_BYTES-1:0]   pattern,
  input  wire logic [3:0]                len_raw,
  input  wire logic                      negate
);
  import wrlm_pkg::*;

  localparam int COL_W = RULE_BYTES + 1;
  localparam int LEN_W = $clog2(COL_W);

  logic [COL_W-1:0] column;
  logic             start;

  logic [3:0]       len_c;
  logic [LEN_W-1:0] len;
  logic [COL_W-1:0] col_init;
  logic [COL_W-1:0] col_base;
  logic [COL_W-1:0] col_new;
  logic             matched;
  stage_t           stage_next;

  assign len_c = (len_raw > 4'(RULE_BYTES)) ? 4'(RULE_BYTES) : len_raw;
  assign len   = len_c[LEN_W-1:0];

  always_comb begin
    // leading stars all match the empty prefix
    col_init    = '0;
    col_init[0] = 1'b1;
    for (int i = 0; i < RULE_BYTES; i++) begin
      col_init[i+1] = col_init[i] && (i < int'(len)) && (pattern[8*i +: 8] == STAR_BYTE);
    end

    col_base = start ? col_init : column;

    col_new = col_base;
    if (stage_in.word.byte_present) begin
      col_new = '0;
      for (int i = 0; i < RULE_BYTES; i++) begin
        if (i < int'(len)) begin
          if (pattern[8*i +: 8] == STAR_BYTE) begin
            col_new[i+1] = col_base[i] | col_base[i+1] | col_new[i];
          end else begin
            col_new[i+1] = (pattern[8*i +: 8] == stage_in.word.name_byte) & col_base[i];
          end
        end
      end
    end

    matched = (len != '0) && col_new[len];

    stage_next = stage_in;
    if (!stage_in.decided && matched) begin
      stage_next.decided  = 1'b1;
      stage_next.accepted = !negate;
      stage_next.rule     = RULE_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_out.valid <= 1'b0;
      start           <= 1'b1;
    end else if (advance) begin
      stage_out.valid <= stage_in.valid;
      if (stage_in.valid) begin
        if (stage_in.word.is_last) begin
          start <= 1'b1;
        end else if (stage_in.word.byte_present) begin
          start <= 1'b0;
        end
      end
    end
    if (advance) begin
      stage_out.word     <= stage_next.word;
      stage_out.decided  <= stage_next.decided;
      stage_out.accepted <= stage_next.accepted;
      stage_out.rule     <= stage_next.rule;
      if (stage_in.valid) begin
        column <= col_new;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/wildcard_rule_list_matcher_top.sv
// path: a last word passes the register of every rule cell and then the output
//   register before its verdict word shows on the output
// throughput: one name word per cycle while the row is not stopped, set by the
//   row of rule cells that the word walks through, one cell per cycle
// the row stops only while a finished verdict waits and the next last word
//   has reached the end of the row
// reset (synchronous, active high): registers cleared, row empty, every cell
//   at the start of a name
// ----------------------------------------------------------------------------
// wildcard_rule_list_matcher_top
// checks a name, one byte per word, against an ordered list of wildcard rules
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_rule_list_matcher_top #(
  parameter int NUM_RULES  = wrlm_pkg::NUM_RULES_DEF,
  parameter int RULE_BYTES = wrlm_pkg::RULE_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // name words in
  input  wire logic                          name_valid,
  output logic                               name_stall,
  input  wire wrlm_pkg::name_word_t          name_word,
  // verdict words out
  output logic                               verdict_valid,
  input  wire logic                          verdict_stall,
  output wrlm_pkg::verdict_word_t            verdict_word,
  // configuration
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [wrlm_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [wrlm_pkg::DATA_W-1:0]   pwdata,
  output logic      [wrlm_pkg::DATA_W-1:0]   prdata,
  output logic                               pready
);
  import wrlm_pkg::*;

  // rules past the register slots do not exist
  localparam int ACTIVE = (NUM_RULES < RULE_SLOTS) ? NUM_RULES : RULE_SLOTS;

  logic [RULE_SLOTS-1:0][63:0] rule_bytes;
  logic [15:0]                 rule_lengths;
  logic [3:0]                  rule_negate_mask;

  wrlm_regs u_regs (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .rule_bytes       (rule_bytes),
    .rule_lengths     (rule_lengths),
    .rule_negate_mask (rule_negate_mask)
  );

  // stage[k] feeds cell k, stage[ACTIVE] is the end of the row
  stage_t stage [ACTIVE+1];
  logic   advance;
  stage_t tail;

  assign tail = stage[ACTIVE];

  // the whole row moves together; it holds only when a verdict is waiting
  // and the word at the end would need the output register too
  assign advance    = !(verdict_valid && verdict_stall && tail.valid && tail.word.is_last);
  assign name_stall = !advance;

  // head of the row: nothing decided yet, default is accept with no rule
  always_comb begin
    stage[0].valid    = name_valid;
    stage[0].word     = name_word;
    stage[0].decided  = 1'b0;
    stage[0].accepted = 1'b1;
    stage[0].rule     = NO_MATCH;
  end

  for (genvar k = 0; k < ACTIVE; k++) begin : g_cell
    wrlm_cell #(
      .RULE_BYTES (RULE_BYTES),
      .RULE_IDX   (3'(k))
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .stage_in  (stage[k]),
      .stage_out (stage[k+1]),
      .pattern   (rule_bytes[k][8*RULE_BYTES-1:0]),
      .len_raw   (rule_lengths[4*k +: 4]),
      .negate    (rule_negate_mask[k])
    );
  end

  // output register: a verdict word leaves only for a last name word
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (advance && tail.valid && tail.word.is_last) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tail.valid && tail.word.is_last) begin
      verdict_word.accepted      <= tail.accepted;
      verdict_word.deciding_rule <= tail.rule;
    end
  end

  // a verdict with no deciding rule is always an accept
  a_default_accept: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && (verdict_word.deciding_rule == NO_MATCH) |-> verdict_word.accepted)
    else $error("no-match verdict rejects");

  // the deciding rule is a real rule or the no-match code
  a_rule_range: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict_word.deciding_rule < 3'(ACTIVE)) ||
                      (verdict_word.deciding_rule == NO_MATCH))
    else $error("deciding rule out of range");

  // input is held off only behind a waiting verdict
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    name_stall |-> verdict_valid && verdict_stall)
    else $error("input stalled without a blocked verdict");

  // a last word that leaves the row shows up as a verdict
  a_last_delivered: assert property (@(posedge clk) disable iff (rst)
    advance && tail.valid && tail.word.is_last |=> verdict_valid)
    else $error("verdict lost");

endmodule

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// streams names byte by byte through the wildcard rule list matcher under a
// series of rule settings, predicts each verdict from its own copy of the
// rule registers and match columns, and checks every verdict word in order
// ----------------------------------------------------------------------------

module testbench;
  import wrlm_pkg::*;

  localparam int NUM_RULES      = NUM_RULES_DEF;
  localparam int RULE_BYTES     = RULE_BYTES_DEF;
  localparam int ACTIVE_RULES   = (NUM_RULES < RULE_SLOTS) ? NUM_RULES : RULE_SLOTS;
  localparam int LATENCY        = ACTIVE_RULES + 1;
  localparam int SETTLE_CYCLES  = 2 * LATENCY + 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_WORDS   = 1000;
  localparam int CLK_PERIOD     = 10;

  // register slots past the list, writes there must change nothing
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;
  localparam logic [2:0] RULE_BYTE_REGS [RULE_SLOTS] =
    '{REG_RULE_BYTES_0, REG_RULE_BYTES_1, REG_RULE_BYTES_2, REG_RULE_BYTES_3};

  localparam logic [7:0] CHAR_A    = 8'h61;
  localparam logic [7:0] CHAR_B    = 8'h62;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                name_valid    = 1'b0;
  logic                name_stall;
  name_word_t          name_word     = '0;
  logic                verdict_valid;
  logic                verdict_stall = 1'b0;
  verdict_word_t       verdict_word;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [ADDR_W-1:0]   paddr         = '0;
  logic [DATA_W-1:0]   pwdata        = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // shadow of the rule registers and of the per-rule match columns
  logic [63:0]         rule_pattern [RULE_SLOTS];
  logic [15:0]         rule_len_field;
  logic [3:0]          negate_field;
  logic [8:0]          match_bits [RULE_SLOTS];
  logic                name_fresh;

  name_word_t          pending_words [$];
  verdict_word_t       expected_verdicts [$];
  verdict_word_t       verdict_due;

  int                  send_gap_pct   = 33;
  int                  recv_stall_pct = 60;
  int                  words_queued;
  int                  words_accepted;
  int                  verdicts_checked;
  int                  names_rejected;
  int                  settings_loaded;
  int                  mismatch_count;
  int                  idle_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  wildcard_rule_list_matcher_top #(
    .NUM_RULES  (NUM_RULES),
    .RULE_BYTES (RULE_BYTES)
  ) u_dut (
    .clk           (clk),
    .rst           (rst),
    .name_valid    (name_valid),
    .name_stall    (name_stall),
    .name_word     (name_word),
    .verdict_valid (verdict_valid),
    .verdict_stall (verdict_stall),
    .verdict_word  (verdict_word),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // ---------------------------------------------------------------- predictor

  // lengths above the byte count clamp to it
  function automatic int unsigned rule_length(input int k);
    int unsigned len;
    len = rule_len_field[4*k +: 4];
    if (len > RULE_BYTES) begin
      len = RULE_BYTES;
    end
    return len;
  endfunction

  function automatic logic [7:0] rule_byte(input int k, input int i);
    return rule_pattern[k][8*i +: 8];
  endfunction

  // empty prefix matches bit zero and every run of leading stars
  function automatic logic [8:0] start_column(input int k);
    logic [8:0]  col;
    int unsigned len;
    int          i;
    col = 9'd1;
    len = rule_length(k);
    for (i = 0; i < len; i++) begin
      if (col[i] && rule_byte(k, i) == STAR_BYTE) begin
        col[i+1] = 1'b1;
      end else begin
        break;
      end
    end
    return col;
  endfunction

  // one step of the glob table: a star may eat nothing, this byte, or more
  function automatic logic [8:0] step_column(input int k, input logic [8:0] prev,
                                             input logic [7:0] c);
    logic [8:0]  nxt;
    logic [7:0]  p;
    int unsigned len;
    int          i;
    nxt = '0;
    len = rule_length(k);
    for (i = 0; i < len; i++) begin
      p = rule_byte(k, i);
      if (p == STAR_BYTE) begin
        nxt[i+1] = prev[i] | prev[i+1] | nxt[i];
      end else begin
        nxt[i+1] = (p == c) ? prev[i] : 1'b0;
      end
    end
    return nxt;
  endfunction

  function automatic void predict_word(input name_word_t w);
    verdict_word_t v;
    int            k;
    int unsigned   len;
    logic          found;
    if (name_fresh) begin
      for (k = 0; k < RULE_SLOTS; k++) begin
        match_bits[k] = start_column(k);
      end
    end
    if (w.byte_present) begin
      for (k = 0; k < RULE_SLOTS; k++) begin
        match_bits[k] = step_column(k, match_bits[k], w.name_byte);
      end
      name_fresh = 1'b0;
    end
    if (w.is_last) begin
      v.accepted      = 1'b1;
      v.deciding_rule = NO_MATCH;
      found           = 1'b0;
      // first present rule that matches decides
      for (k = 0; k < ACTIVE_RULES; k++) begin
        len = rule_length(k);
        if (!found && len != 0 && match_bits[k][len]) begin
          found           = 1'b1;
          v.accepted      = ~negate_field[k];
          v.deciding_rule = 3'(k);
        end
      end
      expected_verdicts.push_back(v);
      if (!v.accepted) begin
        names_rejected++;
      end
      name_fresh = 1'b1;
    end
  endfunction

  // ------------------------------------------------------ configuration port

  // setup cycle, then access cycle; shadow follows once the write has landed
  task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_RULE_BYTES_0: rule_pattern[0] = value;
      REG_RULE_BYTES_1: rule_pattern[1] = value;
      REG_RULE_BYTES_2: rule_pattern[2] = value;
      REG_RULE_BYTES_3: rule_pattern[3] = value;
      REG_RULE_LENGTHS: rule_len_field = value[15:0];
      REG_NEGATE_MASK:  negate_field = value[3:0];
      default: ;
    endcase
  endtask

  task automatic load_setting(input logic [63:0] b0, input logic [63:0] b1,
                              input logic [63:0] b2, input logic [63:0] b3,
                              input logic [15:0] lens, input logic [3:0] neg);
    write_reg(REG_RULE_BYTES_0, b0);
    write_reg(REG_RULE_BYTES_1, b1);
    write_reg(REG_RULE_BYTES_2, b2);
    write_reg(REG_RULE_BYTES_3, b3);
    write_reg(REG_RULE_LENGTHS, {48'd0, lens});
    write_reg(REG_NEGATE_MASK, {60'd0, neg});
    settings_loaded++;
  endtask

  // wait for the row to empty, including words that carry no verdict
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || name_valid || expected_verdicts.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_word(input logic [7:0] b, input logic present, input logic last);
    name_word_t w;
    w.name_byte    = b;
    w.byte_present = present;
    w.is_last      = last;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // an empty string becomes a lone end marker
  task automatic push_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      push_word(s[i], 1'b1, i == s.len() - 1);
    end
    if (s.len() == 0) begin
      push_word(8'h00, 1'b0, 1'b1);
    end
  endtask

  function automatic logic [63:0] pack_pattern(input string s);
    logic [63:0] v;
    int          i;
    v = '0;
    for (i = 0; i < s.len() && i < 8; i++) begin
      v[8*i +: 8] = s[i];
    end
    return v;
  endfunction

  function automatic logic [7:0] pick_rule_byte();
    case ($urandom_range(9))
      0, 1, 2, 3: return STAR_BYTE;
      4, 5:       return CHAR_A;
      6, 7:       return CHAR_B;
      8:          return CHAR_DASH;
      default:    return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_name_byte();
    case ($urandom_range(9))
      0, 1, 2: return CHAR_A;
      3, 4, 5: return CHAR_B;
      6:       return CHAR_DASH;
      7:       return STAR_BYTE;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic random_setting();
    logic [63:0] pat;
    logic [15:0] lens;
    int          k;
    int          i;
    for (k = 0; k < RULE_SLOTS; k++) begin
      if ($urandom_range(15) == 0) begin
        pat = {$urandom, $urandom};
      end else begin
        for (i = 0; i < 8; i++) begin
          pat[8*i +: 8] = pick_rule_byte();
        end
      end
      write_reg(RULE_BYTE_REGS[k], pat);
      // mostly legal lengths, sometimes absent or oversized
      if ($urandom_range(6) == 0) begin
        lens[4*k +: 4] = 4'($urandom_range(15));
      end else begin
        lens[4*k +: 4] = 4'($urandom_range(RULE_BYTES, 1));
      end
    end
    // upper bits carry junk that the register drops
    write_reg(REG_RULE_LENGTHS, {$urandom, 16'($urandom), lens});
    write_reg(REG_NEGATE_MASK, {$urandom, $urandom});
    settings_loaded++;
  endtask

  // mostly names built to fit one of the rules, some free text, some noise
  task automatic random_name();
    logic [7:0] text [$];
    logic [7:0] p;
    int         kind;
    int         k;
    int         i;
    int         run;
    int         len;
    logic       trail;
    kind = $urandom_range(9);
    if (kind == 0) begin
      run = $urandom_range(4, 1);
      for (i = 0; i < run; i++) begin
        push_word(8'($urandom), 1'($urandom), $urandom_range(3) == 0);
      end
      return;
    end
    if (kind <= 6) begin
      k   = $urandom_range(RULE_SLOTS - 1);
      len = rule_length(k);
      for (i = 0; i < len; i++) begin
        p = rule_byte(k, i);
        if (p == STAR_BYTE) begin
          run = $urandom_range(2);
          repeat (run) text.push_back(pick_name_byte());
        end else begin
          text.push_back(p);
        end
      end
      if (text.size() != 0 && $urandom_range(4) == 0) begin
        text[$urandom_range(text.size() - 1)] = pick_name_byte();
      end
    end else begin
      run = $urandom_range(6);
      repeat (run) text.push_back(pick_name_byte());
    end
    trail = (text.size() == 0) || ($urandom_range(7) == 0);
    for (i = 0; i < text.size(); i++) begin
      if ($urandom_range(11) == 0) begin
        push_word(8'($urandom), 1'b0, 1'b0);
      end
      push_word(text[i], 1'b1, (i == text.size() - 1) && !trail);
    end
    if (trail) begin
      push_word(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // ----------------------------------------------------------- name driver

  // a stalled word holds; prediction runs on the edge that takes the word
  always @(posedge clk) begin
    if (rst) begin
      name_valid <= 1'b0;
    end else begin
      if (name_valid && !name_stall) begin
        predict_word(name_word);
        words_accepted++;
      end
      if (!name_valid || !name_stall) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          name_word  <= pending_words.pop_front();
          name_valid <= 1'b1;
        end else begin
          name_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------- verdict monitor

  always @(posedge clk) begin
    if (rst) begin
      verdict_stall <= 1'b0;
    end else begin
      if (verdict_valid && !verdict_stall) begin
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected verdict word, actual accepted %0b rule %0d",
                   $time, verdict_word.accepted, verdict_word.deciding_rule);
          mismatch_count++;
        end else begin
          verdict_due = expected_verdicts.pop_front();
          verdicts_checked++;
          if (verdict_word.accepted !== verdict_due.accepted) begin
            $display("%0t: accepted mismatch, expected %0b actual %0b",
                     $time, verdict_due.accepted, verdict_word.accepted);
            mismatch_count++;
          end
          if (verdict_word.deciding_rule !== verdict_due.deciding_rule) begin
            $display("%0t: deciding_rule mismatch, expected %0d actual %0d",
                     $time, verdict_due.deciding_rule, verdict_word.deciding_rule);
            mismatch_count++;
          end
        end
      end
      verdict_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((name_valid && !name_stall) || (verdict_valid && !verdict_stall) ||
                 (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // -------------------------------------------------------------- sequencer

  initial begin : sequencer
    int phase;
    int phase_end;
    int batch_end;
    int k;
    for (k = 0; k < RULE_SLOTS; k++) begin
      rule_pattern[k] = '0;
    end
    rule_len_field = '0;
    negate_field   = '0;
    name_fresh     = 1'b1;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values: no rule present, everything is a default accept
    push_text("");
    push_text("ab");
    wait_idle();

    // literal dash, leading stars, trailing star, lone star
    load_setting(pack_pattern("-x"), pack_pattern("**b"), pack_pattern("ab*"),
                 pack_pattern("*"), 16'h1332, 4'b0101);
    push_text("-x");
    push_text("b");
    push_text("");
    push_text("abzz");
    push_text("xab");
    push_word(8'h00, 1'b1, 1'b0);
    push_word(8'hFF, 1'b1, 1'b1);
    // word with no byte inside a name, then an end marker closing a name
    push_word(8'hFF, 1'b0, 1'b0);
    push_word(CHAR_B, 1'b1, 1'b1);
    push_word(CHAR_B, 1'b1, 1'b0);
    push_word(8'h00, 1'b0, 1'b1);
    // register write halfway through a name
    push_word(CHAR_A, 1'b1, 1'b0);
    wait_idle();
    write_reg(REG_NEGATE_MASK, 64'hF);
    push_word(CHAR_B, 1'b1, 1'b1);
    wait_idle();

    // all-ones extremes, oversized lengths clamp to eight
    load_setting('1, {8{STAR_BYTE}}, '0, '1, 16'hFFFF, 4'hF);
    push_text("");
    push_word(8'hFF, 1'b1, 1'b1);
    wait_idle();
    write_reg(REG_SPARE_6, '1);
    write_reg(REG_SPARE_7, '1);
    push_text("");
    wait_idle();
    load_setting('0, '0, '0, '0, 16'h0000, 4'h0);
    push_text("a");

    // random part, three idle patterns
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 33;
          recv_stall_pct = 60;
        end
        1: begin
          send_gap_pct   = 60;
          recv_stall_pct = 33;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      phase_end = words_queued + RANDOM_WORDS / 3;
      while (words_queued < phase_end) begin
        // sender holds off until every verdict is in, then new rules
        wait_idle();
        random_setting();
        batch_end = words_queued + $urandom_range(90, 40);
        while (words_queued < batch_end && words_queued < phase_end) begin
          random_name();
        end
      end
    end
    wait_idle();

    $display("checked %0d verdicts (%0d rejections) from %0d name words",
             verdicts_checked, names_rejected, words_accepted);
    $display("%0d rule settings loaded, run under three sender/receiver idle mixes",
             settings_loaded);
    if (expected_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, expected_verdicts.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
